// ===== design/tlvp_pkg.sv =====
// Shared types, constants and tagging function for the TLV packet parser.
`timescale 1ns / 1ps

package tlvp_pkg;

    // Limit on counted TLVs per packet and the counter width it needs
    localparam int MAX_TLVS = 64;
    localparam int CNT_W    = $clog2(MAX_TLVS + 1);

    // Depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_MAGIC       = 2'd0;
    localparam logic [1:0] CFG_VERSION     = 2'd1;
    localparam logic [1:0] CFG_MAX_PACKET  = 2'd2;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd3;

    // Configuration reset values
    localparam logic [7:0]  MAGIC_RESET       = 8'd95;
    localparam logic [7:0]  VERSION_RESET     = 8'd1;
    localparam logic [16:0] MAX_PACKET_RESET  = 17'd1024;
    localparam logic [7:0]  MAX_PAYLOAD_RESET = 8'd192;

    // Header size and data TLV fixed part
    localparam logic [16:0] HEADER_BYTES = 17'd4;
    localparam logic [7:0]  DATA_MIN_LEN = 8'd26;

    // TLV type codes
    localparam logic [7:0] T_PAD1    = 8'd0;
    localparam logic [7:0] T_PADN    = 8'd1;
    localparam logic [7:0] T_ZERO_A  = 8'd2;
    localparam logic [7:0] T_ADDR    = 8'd3;
    localparam logic [7:0] T_NETHASH = 8'd4;
    localparam logic [7:0] T_ZERO_B  = 8'd5;
    localparam logic [7:0] T_NODE    = 8'd6;
    localparam logic [7:0] T_IDONLY  = 8'd7;
    localparam logic [7:0] T_DATA    = 8'd8;
    localparam logic [7:0] T_PAYLOAD = 8'd9;

    // Field codes
    localparam logic [3:0] F_HEADER   = 4'd0;
    localparam logic [3:0] F_PAD      = 4'd1;
    localparam logic [3:0] F_TYPE     = 4'd2;
    localparam logic [3:0] F_LENGTH   = 4'd3;
    localparam logic [3:0] F_ID       = 4'd4;
    localparam logic [3:0] F_SEQNO    = 4'd5;
    localparam logic [3:0] F_NODEHASH = 4'd6;
    localparam logic [3:0] F_NETHASH  = 4'd7;
    localparam logic [3:0] F_IP       = 4'd8;
    localparam logic [3:0] F_PORT     = 4'd9;
    localparam logic [3:0] F_PAYLOAD  = 4'd10;
    localparam logic [3:0] F_SKIPPED  = 4'd11;
    localparam logic [3:0] F_EXTRA    = 4'd12;
    localparam logic [3:0] F_IGNORED  = 4'd13;

    // Error codes
    localparam logic [3:0] E_NONE        = 4'd0;
    localparam logic [3:0] E_MAGIC       = 4'd1;
    localparam logic [3:0] E_VERSION     = 4'd2;
    localparam logic [3:0] E_TOO_LONG    = 4'd3;
    localparam logic [3:0] E_OVERRUN     = 4'd4;
    localparam logic [3:0] E_PADN        = 4'd5;
    localparam logic [3:0] E_LEN_NONZERO = 4'd6;
    localparam logic [3:0] E_DATA_LEN    = 4'd7;
    localparam logic [3:0] E_TOO_MANY    = 4'd8;

    // Parser phases
    typedef enum logic [3:0] {
        PH_H0,
        PH_H1,
        PH_H2,
        PH_H3,
        PH_TYPE,
        PH_LEN,
        PH_VALUE,
        PH_DONE,
        PH_ERR
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] tlv_kind;
        logic [3:0] field_code;
        logic [7:0] field_offset;
        logic       tlv_done;
        logic       packet_done;
        logic [3:0] error_code;
        logic [6:0] tlv_total;
    } out_t;

    typedef struct packed {
        logic [7:0]  magic;
        logic [7:0]  version;
        logic [16:0] max_packet;
        logic [7:0]  max_payload;
    } cfg_t;

    // Classified request passed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] kind;
        logic [3:0] field;
        logic [7:0] offset;
        logic       is_value;
        logic       tlv_done;
        logic       packet_done;
        logic [3:0] error_code;
        logic [6:0] tlv_total;
    } rec_t;

    typedef struct packed {
        logic [3:0] field;
        logic [7:0] offset;
    } tag_t;

    // Map a value byte of a TLV to its field and offset within the field
    function automatic tag_t tag_value(logic [7:0] t, logic [7:0] o);
        tag_t r;
        r.field  = F_SKIPPED;
        r.offset = o;
        case (t)
            T_PADN:    r.field = F_PAD;
            T_ADDR:
            begin
                if (o < 8'd16)
                begin
                    r.field = F_IP;
                end
                else if (o < 8'd18)
                begin
                    r.field  = F_PORT;
                    r.offset = o - 8'd16;
                end
                else
                begin
                    r.field  = F_EXTRA;
                    r.offset = o - 8'd18;
                end
            end
            T_NETHASH:
            begin
                if (o < 8'd16)
                begin
                    r.field = F_NETHASH;
                end
                else
                begin
                    r.field  = F_EXTRA;
                    r.offset = o - 8'd16;
                end
            end
            T_NODE, T_DATA:
            begin
                if (o < 8'd8)
                begin
                    r.field = F_ID;
                end
                else if (o < 8'd10)
                begin
                    r.field  = F_SEQNO;
                    r.offset = o - 8'd8;
                end
                else if (o < DATA_MIN_LEN)
                begin
                    r.field  = F_NODEHASH;
                    r.offset = o - 8'd10;
                end
                else
                begin
                    r.field  = (t == T_DATA) ? F_PAYLOAD : F_EXTRA;
                    r.offset = o - DATA_MIN_LEN;
                end
            end
            T_IDONLY:
            begin
                if (o < 8'd8)
                begin
                    r.field = F_ID;
                end
                else
                begin
                    r.field  = F_EXTRA;
                    r.offset = o - 8'd8;
                end
            end
            T_PAYLOAD: r.field = F_PAYLOAD;
            default:   r.field = F_SKIPPED;
        endcase
        return r;
    endfunction

endpackage

// ===== design/tlv_packet_parser.sv =====
// A byte's result passes through the queue and then the output register before it is offered.
// Throughput: one byte per cycle while the queue is not full; the parse state in the front end updates once per byte.
// A four-entry queue lets the front keep taking bytes while the output is stalled.
// Reset (rst_n, asynchronous, active low) clears the parse to wait for the magic byte,
// empties the queue and output, and loads the configuration defaults.
`timescale 1ns / 1ps

module tlv_packet_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  tlvp_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output tlvp_pkg::out_t  out_data,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [16:0]     cfg_data
);

    tlvp_pkg::cfg_t  cfg_reg, cfg_next;
    logic            queue_full;
    logic            queue_empty;
    logic            push;
    logic            pop;
    tlvp_pkg::rec_t  push_data;
    tlvp_pkg::rec_t  head;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tlvp_pkg::CFG_MAGIC:       cfg_next.magic       = cfg_data[7:0];
                tlvp_pkg::CFG_VERSION:     cfg_next.version     = cfg_data[7:0];
                tlvp_pkg::CFG_MAX_PACKET:  cfg_next.max_packet  = cfg_data;
                tlvp_pkg::CFG_MAX_PAYLOAD: cfg_next.max_payload = cfg_data[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic       <= tlvp_pkg::MAGIC_RESET;
            cfg_reg.version     <= tlvp_pkg::VERSION_RESET;
            cfg_reg.max_packet  <= tlvp_pkg::MAX_PACKET_RESET;
            cfg_reg.max_payload <= tlvp_pkg::MAX_PAYLOAD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tlvp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .push_data  (push_data)
    );

    tlvp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    tlvp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

// ===== design/tlvp_front.sv =====
// Front end: accepts bytes, runs the packet parse state and classifies each byte.
`timescale 1ns / 1ps

module tlvp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  tlvp_pkg::cfg_t   cfg,
    input  logic             in_valid,
    input  tlvp_pkg::in_t    in_data,
    input  logic             queue_full,
    output logic             in_stall,
    output logic             push,
    output tlvp_pkg::rec_t   push_data
);

    tlvp_pkg::phase_t          phase_reg, phase_next;
    logic [15:0]               body_len_reg, body_len_next;
    logic [15:0]               body_pos_reg, body_pos_next;
    logic [7:0]                type_reg, type_next;
    logic [7:0]                remain_reg, remain_next;
    logic [7:0]                offset_reg, offset_next;
    logic [tlvp_pkg::CNT_W-1:0] count_reg, count_next;
    logic [3:0]                error_reg, error_next;

    // Current state, with a packet start marker clearing the parse
    tlvp_pkg::phase_t          cur_phase;
    logic [15:0]               cur_len;
    logic [15:0]               cur_pos;
    logic [7:0]                cur_type;
    logic [7:0]                cur_remain;
    logic [7:0]                cur_offset;
    logic [tlvp_pkg::CNT_W-1:0] cur_count;
    logic [3:0]                cur_error;

    logic [7:0]  b;
    logic [15:0] len_full;
    logic [15:0] pos_inc;
    logic [15:0] len_room;
    logic [7:0]  remain_dec;
    logic        counted_type;
    logic        count_full;
    logic        pos_at_end;
    logic        accept;

    logic [3:0]  err;
    logic        tlv_end;
    logic        pkt_end;

    assign accept   = in_valid && !queue_full;
    assign in_stall = queue_full;
    assign push     = accept;

    assign b          = in_data.in_byte;
    assign cur_phase  = in_data.first_byte ? tlvp_pkg::PH_H0 : phase_reg;
    assign cur_len    = in_data.first_byte ? 16'd0 : body_len_reg;
    assign cur_pos    = in_data.first_byte ? 16'd0 : body_pos_reg;
    assign cur_type   = in_data.first_byte ? 8'd0 : type_reg;
    assign cur_remain = in_data.first_byte ? 8'd0 : remain_reg;
    assign cur_offset = in_data.first_byte ? 8'd0 : offset_reg;
    assign cur_count  = in_data.first_byte ? '0 : count_reg;
    assign cur_error  = in_data.first_byte ? tlvp_pkg::E_NONE : error_reg;

    assign len_full     = {cur_len[15:8], b};
    assign pos_inc      = cur_pos + 16'd1;
    assign len_room     = cur_len - pos_inc;
    assign remain_dec   = cur_remain - 8'd1;
    assign pos_at_end   = pos_inc >= cur_len;
    assign counted_type = (cur_type >= tlvp_pkg::T_PADN) && (cur_type <= tlvp_pkg::T_PAYLOAD);
    assign count_full   = cur_count >= tlvp_pkg::CNT_W'(tlvp_pkg::MAX_TLVS);

    // Check the byte against the current phase
    always_comb
    begin
        err     = tlvp_pkg::E_NONE;
        tlv_end = 1'b0;
        pkt_end = 1'b0;
        unique case (cur_phase)
            tlvp_pkg::PH_H0:
            begin
                if (b != cfg.magic)
                begin
                    err = tlvp_pkg::E_MAGIC;
                end
            end
            tlvp_pkg::PH_H1:
            begin
                if (b != cfg.version)
                begin
                    err = tlvp_pkg::E_VERSION;
                end
            end
            tlvp_pkg::PH_H2:
            begin
                err = tlvp_pkg::E_NONE;
            end
            tlvp_pkg::PH_H3:
            begin
                if ({1'b0, len_full} + tlvp_pkg::HEADER_BYTES > cfg.max_packet)
                begin
                    err = tlvp_pkg::E_TOO_LONG;
                end
                else if (len_full == 16'd0)
                begin
                    pkt_end = 1'b1;
                end
            end
            tlvp_pkg::PH_TYPE:
            begin
                if (b == tlvp_pkg::T_PAD1)
                begin
                    tlv_end = 1'b1;
                end
                else if (pos_at_end)
                begin
                    err = tlvp_pkg::E_OVERRUN;
                end
            end
            tlvp_pkg::PH_LEN:
            begin
                if ({8'd0, b} > len_room)
                begin
                    err = tlvp_pkg::E_OVERRUN;
                end
                else if ((cur_type == tlvp_pkg::T_ZERO_A || cur_type == tlvp_pkg::T_ZERO_B)
                         && b != 8'd0)
                begin
                    err = tlvp_pkg::E_LEN_NONZERO;
                end
                else if (cur_type == tlvp_pkg::T_DATA && (b < tlvp_pkg::DATA_MIN_LEN
                         || (b - tlvp_pkg::DATA_MIN_LEN) > cfg.max_payload))
                begin
                    err = tlvp_pkg::E_DATA_LEN;
                end
                else if (b == 8'd0)
                begin
                    if (counted_type && count_full)
                    begin
                        err = tlvp_pkg::E_TOO_MANY;
                    end
                    else
                    begin
                        tlv_end = 1'b1;
                    end
                end
            end
            tlvp_pkg::PH_VALUE:
            begin
                if (cur_type == tlvp_pkg::T_PADN && b != 8'd0)
                begin
                    err = tlvp_pkg::E_PADN;
                end
                else if (remain_dec == 8'd0)
                begin
                    if (counted_type && count_full)
                    begin
                        err = tlvp_pkg::E_TOO_MANY;
                    end
                    else
                    begin
                        tlv_end = 1'b1;
                    end
                end
            end
            tlvp_pkg::PH_DONE, tlvp_pkg::PH_ERR:
            begin
                err = tlvp_pkg::E_NONE;
            end
            default:
            begin
                err = tlvp_pkg::E_NONE;
            end
        endcase
        if (tlv_end && pos_at_end)
        begin
            pkt_end = 1'b1;
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = cur_phase;
        if (err != tlvp_pkg::E_NONE)
        begin
            phase_next = tlvp_pkg::PH_ERR;
        end
        else if (tlv_end)
        begin
            phase_next = pkt_end ? tlvp_pkg::PH_DONE : tlvp_pkg::PH_TYPE;
        end
        else
        begin
            unique case (cur_phase)
                tlvp_pkg::PH_H0:    phase_next = tlvp_pkg::PH_H1;
                tlvp_pkg::PH_H1:    phase_next = tlvp_pkg::PH_H2;
                tlvp_pkg::PH_H2:    phase_next = tlvp_pkg::PH_H3;
                tlvp_pkg::PH_H3:    phase_next = pkt_end ? tlvp_pkg::PH_DONE : tlvp_pkg::PH_TYPE;
                tlvp_pkg::PH_TYPE:  phase_next = tlvp_pkg::PH_LEN;
                tlvp_pkg::PH_LEN:   phase_next = tlvp_pkg::PH_VALUE;
                tlvp_pkg::PH_VALUE: phase_next = tlvp_pkg::PH_VALUE;
                tlvp_pkg::PH_DONE:  phase_next = tlvp_pkg::PH_DONE;
                tlvp_pkg::PH_ERR:   phase_next = tlvp_pkg::PH_ERR;
                default:            phase_next = tlvp_pkg::PH_ERR;
            endcase
        end
    end

    // Parse registers and the classified request
    always_comb
    begin
        body_len_next = cur_len;
        body_pos_next = cur_pos;
        type_next     = cur_type;
        remain_next   = cur_remain;
        offset_next   = cur_offset;
        count_next    = cur_count;
        error_next    = (err != tlvp_pkg::E_NONE) ? err : cur_error;

        push_data.data     = b;
        push_data.kind     = 8'd0;
        push_data.field    = tlvp_pkg::F_IGNORED;
        push_data.offset   = 8'd0;
        push_data.is_value = 1'b0;

        unique case (cur_phase)
            tlvp_pkg::PH_H0, tlvp_pkg::PH_H1, tlvp_pkg::PH_H2, tlvp_pkg::PH_H3:
            begin
                push_data.field  = tlvp_pkg::F_HEADER;
                push_data.offset = {4'd0, cur_phase};
                if (cur_phase == tlvp_pkg::PH_H2)
                begin
                    body_len_next = {b, 8'd0};
                end
                else if (cur_phase == tlvp_pkg::PH_H3)
                begin
                    body_len_next = len_full;
                end
            end
            tlvp_pkg::PH_TYPE:
            begin
                body_pos_next = pos_inc;
                if (b == tlvp_pkg::T_PAD1)
                begin
                    push_data.field = tlvp_pkg::F_PAD;
                end
                else
                begin
                    push_data.field = tlvp_pkg::F_TYPE;
                    push_data.kind  = b;
                    type_next       = b;
                end
            end
            tlvp_pkg::PH_LEN:
            begin
                body_pos_next   = pos_inc;
                push_data.field = tlvp_pkg::F_LENGTH;
                push_data.kind  = cur_type;
                remain_next     = b;
                offset_next     = 8'd0;
            end
            tlvp_pkg::PH_VALUE:
            begin
                body_pos_next      = pos_inc;
                push_data.kind     = cur_type;
                push_data.offset   = cur_offset;
                push_data.is_value = 1'b1;
                remain_next        = remain_dec;
                offset_next        = cur_offset + 8'd1;
            end
            tlvp_pkg::PH_DONE, tlvp_pkg::PH_ERR:
            begin
                push_data.field = tlvp_pkg::F_IGNORED;
            end
            default:
            begin
                push_data.field = tlvp_pkg::F_IGNORED;
            end
        endcase

        // Count completed TLVs of counted types; single Pad1 bytes are excluded, PadN TLVs are counted
        if (tlv_end && cur_phase != tlvp_pkg::PH_TYPE && counted_type)
        begin
            count_next = cur_count + tlvp_pkg::CNT_W'(1);
        end

        push_data.tlv_done    = tlv_end;
        push_data.packet_done = pkt_end && (err == tlvp_pkg::E_NONE);
        push_data.error_code  = error_next;
        push_data.tlv_total   = 7'(count_next);
    end

    // Advance parse state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tlvp_pkg::PH_H0;
            body_len_reg <= 16'd0;
            body_pos_reg <= 16'd0;
            type_reg     <= 8'd0;
            remain_reg   <= 8'd0;
            offset_reg   <= 8'd0;
            count_reg    <= '0;
            error_reg    <= tlvp_pkg::E_NONE;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            body_len_reg <= body_len_next;
            body_pos_reg <= body_pos_next;
            type_reg     <= type_next;
            remain_reg   <= remain_next;
            offset_reg   <= offset_next;
            count_reg    <= count_next;
            error_reg    <= error_next;
        end
    end

endmodule

// ===== design/tlvp_queue.sv =====
// Short FIFO of classified requests between front and back.
`timescale 1ns / 1ps

module tlvp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tlvp_pkg::rec_t  push_data,
    input  logic            pop,
    output tlvp_pkg::rec_t  pop_data,
    output logic            full,
    output logic            empty
);

    tlvp_pkg::rec_t                  entry_reg [tlvp_pkg::QDEPTH];
    logic [tlvp_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [tlvp_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [tlvp_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full     = count_reg == tlvp_pkg::QCNT_W'(tlvp_pkg::QDEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + tlvp_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + tlvp_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + tlvp_pkg::QCNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - tlvp_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/tlvp_back.sv =====
// Back end: tags value bytes with their field and drives the output register.
`timescale 1ns / 1ps

module tlvp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            queue_empty,
    input  tlvp_pkg::rec_t  head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output tlvp_pkg::out_t  out_data
);

    logic            out_valid_reg, out_valid_next;
    tlvp_pkg::out_t  out_data_reg, out_data_next;
    tlvp_pkg::tag_t  tag;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Take the head request when the output register is free or draining
    assign pop = !queue_empty && (!out_valid_reg || !out_stall);

    assign tag = tlvp_pkg::tag_value(head.kind, head.offset);

    // Build the result from the head request
    always_comb
    begin
        out_data_next.out_byte     = head.data;
        out_data_next.tlv_kind     = head.kind;
        out_data_next.field_code   = head.is_value ? tag.field : head.field;
        out_data_next.field_offset = head.is_value ? tag.offset : head.offset;
        out_data_next.tlv_done     = head.tlv_done;
        out_data_next.packet_done  = head.packet_done;
        out_data_next.error_code   = head.error_code;
        out_data_next.tlv_total    = head.tlv_total;

        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
